// ===== hdl/ant_pkg.sv =====
package ant_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OUT_W    = 5;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_AGE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd120;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] seen;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic evaluate;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_more;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/aging_neighbor_table_top.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------------
// request  | s_valid / s_ready    | s_command, s_ip_addr, s_port_num, s_now_seconds
// result   | m_valid / m_ready    | m_status, m_match_index, m_entry_count, m_removed_count
// config   | cfg_wr_en            | cfg_wr_data (timeout in seconds)
//
// Clear, load and unused codes pass from S_IDLE through S_READ to S_FINISH; the result
// is registered in S_FINISH once the result register is free.
// Refresh, remove and age sweep walk the table through one RAM read port, each visited
// entry taking an S_READ and an S_EVAL state; a refresh stops at its first hit.
// Reset is synchronous, active low; the table needs no clearing pass.
// One request in flight; the next is taken while a result still waits on m_ready.
module aging_neighbor_table_top #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [15:0]                       cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ant_pkg::CMD_W-1:0]         s_command,
    input  logic [31:0]                       s_ip_addr,
    input  logic [15:0]                       s_port_num,
    input  logic [31:0]                       s_now_seconds,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ant_pkg::STATUS_W-1:0]      m_status,
    output logic [ant_pkg::OUT_W-1:0]         m_match_index,
    output logic [ant_pkg::OUT_W-1:0]         m_entry_count,
    output logic [ant_pkg::OUT_W-1:0]         m_removed_count
);

    ant_pkg::ctrl_cmd_t  cmd;
    ant_pkg::dp_status_t status;

    ant_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ant_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_command       (s_command),
        .s_ip_addr       (s_ip_addr),
        .s_port_num      (s_port_num),
        .s_now_seconds   (s_now_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_match_index   (m_match_index),
        .m_entry_count   (m_entry_count),
        .m_removed_count (m_removed_count),
        .cmd             (cmd),
        .status          (status)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in progress");

    a_full_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ant_pkg::ST_FULL) |->
            (m_match_index == '0 && m_removed_count == '0))
        else $error("full-table result carries index or removal count");

    a_nomatch_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ant_pkg::ST_NOMATCH) |->
            (m_match_index == '0 && m_removed_count == '0))
        else $error("no-match result carries index or removal count");

    a_finish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.out_free)
        else $error("result written over one not yet taken");

endmodule

// ===== hdl/ant_ram.sv =====
module ant_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/ant_ctrl.sv =====
module ant_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ant_pkg::dp_status_t    status,
    output ant_pkg::ctrl_cmd_t     cmd
);

    ant_pkg::state_t state_reg;
    ant_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ant_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ant_pkg::S_IDLE: begin
                if (s_valid) state_next = ant_pkg::S_READ;
            end
            ant_pkg::S_READ: begin
                state_next = status.scan_more ? ant_pkg::S_EVAL : ant_pkg::S_FINISH;
            end
            ant_pkg::S_EVAL: begin
                state_next = ant_pkg::S_READ;
            end
            ant_pkg::S_FINISH: begin
                if (status.out_free) state_next = ant_pkg::S_IDLE;
            end
            default: state_next = ant_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.evaluate = 1'b0;
        cmd.finish   = 1'b0;
        unique case (state_reg)
            ant_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ant_pkg::S_READ: begin
                // wait for the table read
            end
            ant_pkg::S_EVAL: begin
                cmd.evaluate = 1'b1;
            end
            ant_pkg::S_FINISH: begin
                cmd.finish = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/ant_datapath.sv =====
module ant_datapath #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [15:0]                         cfg_wr_data,
    input  logic [ant_pkg::CMD_W-1:0]           s_command,
    input  logic [31:0]                         s_ip_addr,
    input  logic [15:0]                         s_port_num,
    input  logic [31:0]                         s_now_seconds,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ant_pkg::STATUS_W-1:0]        m_status,
    output logic [ant_pkg::OUT_W-1:0]           m_match_index,
    output logic [ant_pkg::OUT_W-1:0]           m_entry_count,
    output logic [ant_pkg::OUT_W-1:0]           m_removed_count,
    input  ant_pkg::ctrl_cmd_t                  cmd,
    output ant_pkg::dp_status_t                 status
);

    localparam int unsigned IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned ENTRY_W = $bits(ant_pkg::entry_t);
    localparam int unsigned OUT_W   = ant_pkg::OUT_W;

    // request held for the whole item
    logic [ant_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [31:0]               addr_reg, addr_next;
    logic [15:0]               port_reg, port_next;
    logic [31:0]               now_reg, now_next;

    logic [15:0]      timeout_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             found_reg, found_next;

    logic                      m_valid_reg, m_valid_next;
    logic [ant_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [OUT_W-1:0]          m_index_reg, m_index_next;
    logic [OUT_W-1:0]          m_count_reg, m_count_next;
    logic [OUT_W-1:0]          m_removed_reg, m_removed_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_wa;
    ant_pkg::entry_t      ram_wd;
    ant_pkg::entry_t      ram_rd;
    logic [ENTRY_W-1:0]   ram_rd_bits;

    logic is_refresh, is_remove, is_age, is_scan, is_load;
    logic hit, expired, drop, full;
    logic [31:0] age;

    logic [CNT_W-1:0] res_index, res_count, res_removed;
    logic [CNT_W+OUT_W-1:0] wide_index, wide_count, wide_removed;

    assign is_load    = (cmd_reg == ant_pkg::CMD_LOAD);
    assign is_refresh = (cmd_reg == ant_pkg::CMD_REFRESH);
    assign is_remove  = (cmd_reg == ant_pkg::CMD_REMOVE);
    assign is_age     = (cmd_reg == ant_pkg::CMD_AGE);
    assign is_scan    = is_refresh || is_remove || is_age;
    assign full       = (fill_reg == CNT_W'(TABLE_DEPTH));

    assign ram_rd  = ant_pkg::entry_t'(ram_rd_bits);
    assign hit     = (ram_rd.addr == addr_reg) && (ram_rd.port == port_reg);
    assign age     = now_reg - ram_rd.seen;
    assign expired = (age >= {16'd0, timeout_reg});
    assign drop    = (is_remove && hit && !found_reg) || (is_age && expired);

    assign status.scan_more = is_scan && (rd_reg != fill_reg) && !(is_refresh && found_reg);
    assign status.out_free  = !m_valid_reg || m_ready;

    ant_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (rd_reg[IDX_W-1:0]),
        .rd_data (ram_rd_bits)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= ant_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        addr_reg      <= addr_next;
        port_reg      <= port_next;
        now_reg       <= now_next;
        rd_reg        <= rd_next;
        wr_reg        <= wr_next;
        pos_reg       <= pos_next;
        found_reg     <= found_next;
        m_status_reg  <= m_status_next;
        m_index_reg   <= m_index_next;
        m_count_reg   <= m_count_next;
        m_removed_reg <= m_removed_next;
    end

    // result fields before masking to the port width
    always_comb begin
        res_index   = '0;
        res_count   = fill_reg;
        res_removed = '0;
        unique case (cmd_reg)
            ant_pkg::CMD_CLEAR: begin
                res_count   = '0;
                res_removed = fill_reg;
            end
            ant_pkg::CMD_LOAD: begin
                if (!full) begin
                    res_index = fill_reg;
                    res_count = fill_reg + CNT_W'(1);
                end
            end
            ant_pkg::CMD_REFRESH: begin
                if (found_reg) res_index = pos_reg;
            end
            ant_pkg::CMD_REMOVE, ant_pkg::CMD_AGE: begin
                if (is_remove && found_reg) res_index = pos_reg;
                res_count   = wr_reg;
                res_removed = fill_reg - wr_reg;
            end
            default: begin
                res_count = fill_reg;
            end
        endcase
    end

    assign wide_index   = {{OUT_W{1'b0}}, res_index};
    assign wide_count   = {{OUT_W{1'b0}}, res_count};
    assign wide_removed = {{OUT_W{1'b0}}, res_removed};

    always_comb begin
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        port_next      = port_reg;
        now_next       = now_reg;
        fill_next      = fill_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_index_next   = m_index_reg;
        m_count_next   = m_count_reg;
        m_removed_next = m_removed_reg;
        ram_we         = 1'b0;
        ram_wa         = wr_reg[IDX_W-1:0];
        ram_wd         = ram_rd;

        if (cmd.capture) begin
            cmd_next   = s_command;
            addr_next  = s_ip_addr;
            port_next  = s_port_num;
            now_next   = s_now_seconds;
            rd_next    = '0;
            wr_next    = '0;
            pos_next   = '0;
            found_next = 1'b0;
        end

        if (cmd.evaluate) begin
            rd_next = rd_reg + CNT_W'(1);
            if (is_refresh) begin
                if (hit) begin
                    // restamp in place and stop the walk
                    ram_we      = 1'b1;
                    ram_wa      = rd_reg[IDX_W-1:0];
                    ram_wd.seen = now_reg;
                    found_next  = 1'b1;
                    pos_next    = rd_reg;
                end
            end else if (drop) begin
                if (is_remove) begin
                    found_next = 1'b1;
                    pos_next   = rd_reg;
                end
            end else begin
                // compact: survivor moves down to the write pointer
                ram_we  = 1'b1;
                ram_wa  = wr_reg[IDX_W-1:0];
                wr_next = wr_reg + CNT_W'(1);
            end
        end

        if (cmd.finish) begin
            m_valid_next   = 1'b1;
            m_index_next   = wide_index[OUT_W-1:0];
            m_count_next   = wide_count[OUT_W-1:0];
            m_removed_next = wide_removed[OUT_W-1:0];
            m_status_next  = ant_pkg::ST_DONE;
            fill_next      = res_count;
            if (is_load) begin
                if (full) begin
                    m_status_next = ant_pkg::ST_FULL;
                end else begin
                    ram_we = 1'b1;
                    ram_wa = fill_reg[IDX_W-1:0];
                    ram_wd = '{addr: addr_reg, port: port_reg, seen: now_reg};
                end
            end else if ((is_refresh || is_remove) && !found_reg) begin
                m_status_next = ant_pkg::ST_NOMATCH;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_match_index   = m_index_reg;
    assign m_entry_count   = m_count_reg;
    assign m_removed_count = m_removed_reg;

endmodule
